// ===== design/stick_expo_deadband_shaper_defines.svh =====
// ============================================================================
// stick_expo_deadband_shaper_defines.svh
// Assertion macros shared by the stick shaper checker.
// ============================================================================
`ifndef STICK_EXPO_DEADBAND_SHAPER_DEFINES_SVH
`define STICK_EXPO_DEADBAND_SHAPER_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define SEDSHP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SEDSHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/sedshp_pkg.sv =====
// ============================================================================
// sedshp_pkg
// Shared widths, axis codes and register indexes of the stick shaper.
// ============================================================================
`timescale 1ns / 1ps
package sedshp_pkg;

  // Field widths
  localparam int AXIS_W     = 2;
  localparam int VAL_W      = 16;
  localparam int DZ_W       = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_SHAPED = 3;

  // Axis codes
  localparam logic [AXIS_W-1:0] AXIS_ROLL     = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_PITCH    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_YAW      = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_THROTTLE = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_MODE,
    REG_FIRST_ROLL_EXPO,
    REG_FIRST_PITCH_EXPO,
    REG_FIRST_YAW_EXPO,
    REG_SECOND_ROLL_EXPO,
    REG_SECOND_PITCH_EXPO,
    REG_SECOND_YAW_EXPO,
    REG_DEAD_ZONE
  } cfg_reg_e;

endpackage

// ===== design/stick_expo_deadband_shaper.sv =====
// ============================================================================
// stick_expo_deadband_shaper
// Per-axis expo curve, clamp and deadband rescale for radio stick samples.
// ============================================================================
// Throughput: one word per cycle while the output is not stalled; the deadband
//   divide resolves one quotient bit per pipeline stage, FRAC_BITS + 1 stages in all.
// Back-pressure stalls only the stages that hold data; bubbles close up.
// Reset clears the valid bits and the configuration registers.
`timescale 1ns / 1ps
module stick_expo_deadband_shaper import sedshp_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [AXIS_W-1:0]      axis_sel_i,
  input  logic signed [VAL_W-1:0] stick_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [AXIS_W-1:0]      axis_out_o,
  output logic signed [VAL_W-1:0] shaped_value_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // Widths
  localparam int MW  = FRAC_BITS + 1;                 // magnitude up to one
  localparam int PW  = 2 * MW;                        // product width
  localparam int QW  = MW;                            // quotient bits
  localparam int XW  = VAL_W + 1;                     // abs of raw input
  localparam int AW  = (MW > XW) ? MW : XW;           // clamp compare
  localparam int EW  = (FRAC_BITS + 2 > VAL_W + 8) ? FRAC_BITS + 2 : VAL_W + 8;
  localparam int DW  = (MW > DZ_W) ? MW : DZ_W;       // deadband compare
  localparam int OW  = (MW + 1 > VAL_W + 1) ? MW + 1 : VAL_W + 1;

  // Stage map
  localparam int ST1     = 0;
  localparam int ST2     = 1;
  localparam int ST3     = 2;
  localparam int ST4     = 3;
  localparam int ST5     = 4;
  localparam int ST_DIV0 = 5;
  localparam int NS      = ST_DIV0 + QW + 1;
  localparam int ST_OUT  = NS - 1;

  // Constants
  localparam logic [AW-1:0]        ONE_A   = AW'(1) << FRAC_BITS;
  localparam logic [MW-1:0]        ONE_M   = MW'(1) << FRAC_BITS;
  localparam logic [PW-1:0]        HALF_P  = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [EW-1:0] ONE_E   = EW'(1) << FRAC_BITS;
  localparam logic signed [EW-1:0] HUNDRED = EW'(100);
  localparam logic signed [OW-1:0] VMAX    = OW'((1 << (VAL_W - 1)) - 1);
  localparam logic signed [OW-1:0] VMIN    = -OW'(1 << (VAL_W - 1));

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic [VAL_W-1:0]  raw;
    logic              neg;
    logic              thr;
    logic              bypass;
    logic              zero;
    logic [MW-1:0]     mag;
    logic [MW-1:0]     den;
    logic [MW-1:0]     rem;
    logic [QW-1:0]     nq;
  } div_t;

  // Configuration registers
  logic              rate_mode_q;
  logic [VAL_W-1:0]  first_expo_q  [NUM_SHAPED];
  logic [VAL_W-1:0]  second_expo_q [NUM_SHAPED];
  logic [DZ_W-1:0]   dead_zone_q;

  // Handshake chain
  logic [NS-1:0] v_q, v_d, v_in, en;

  // Stage 1
  logic signed [XW-1:0] xs;
  logic [XW-1:0]        ax;
  logic [AW-1:0]        ax_a, m1;
  logic [VAL_W-1:0]     e_raw;
  logic signed [EW-1:0] e_ext, e100, eu;
  logic [AXIS_W-1:0]    s1_axis_q;
  logic [VAL_W-1:0]     s1_raw_q;
  logic                 s1_neg_q, s1_thr_q, s1_exp_q;
  logic [MW-1:0]        s1_m_q, s1_e_q;

  // Stage 2
  logic [PW-1:0]        p2;
  logic [AXIS_W-1:0]    s2_axis_q;
  logic [VAL_W-1:0]     s2_raw_q;
  logic                 s2_neg_q, s2_thr_q, s2_exp_q;
  logic [MW-1:0]        s2_m_q, s2_e_q, s2_m2_q;

  // Stage 3
  logic [PW-1:0]        p3;
  logic [MW-1:0]        m3;
  logic [AXIS_W-1:0]    s3_axis_q;
  logic [VAL_W-1:0]     s3_raw_q;
  logic                 s3_neg_q, s3_thr_q, s3_exp_q;
  logic [MW-1:0]        s3_m_q, s3_e_q, s3_d_q;

  // Stage 4
  logic [PW-1:0]        y4;
  logic [AXIS_W-1:0]    s4_axis_q;
  logic [VAL_W-1:0]     s4_raw_q;
  logic                 s4_neg_q, s4_thr_q;
  logic [MW-1:0]        s4_mag_q;

  // Stage 5 and divider
  logic [DW-1:0]        db_d, mag_d;
  logic [MW-1:0]        den5, diff5;
  logic [PW-1:0]        num5;
  div_t                 s5_d, s5_q;
  div_t                 dv_d [QW];
  div_t                 dv_q [QW];

  // Output stage
  div_t                 fin;
  logic [MW-1:0]        umag;
  logic signed [OW-1:0] sv, sat;
  logic [AXIS_W-1:0]    out_axis_q;
  logic signed [VAL_W-1:0] out_val_q;

  // --------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_mode_q <= 1'b0;
      dead_zone_q <= '0;
      for (int i = 0; i < NUM_SHAPED; i++) begin
        first_expo_q[i]  <= '0;
        second_expo_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RATE_MODE:         rate_mode_q <= cfg_data_i[0];
        REG_FIRST_ROLL_EXPO:   first_expo_q[AXIS_ROLL] <= cfg_data_i;
        REG_FIRST_PITCH_EXPO:  first_expo_q[AXIS_PITCH] <= cfg_data_i;
        REG_FIRST_YAW_EXPO:    first_expo_q[AXIS_YAW] <= cfg_data_i;
        REG_SECOND_ROLL_EXPO:  second_expo_q[AXIS_ROLL] <= cfg_data_i;
        REG_SECOND_PITCH_EXPO: second_expo_q[AXIS_PITCH] <= cfg_data_i;
        REG_SECOND_YAW_EXPO:   second_expo_q[AXIS_YAW] <= cfg_data_i;
        REG_DEAD_ZONE:         dead_zone_q <= cfg_data_i[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits and per-stage enables; a stage loads when empty or draining
  assign v_in = {v_q[NS-2:0], in_valid_i};

  for (genvar k = 0; k < NS; k++) begin : g_en
    if (k == NS - 1) begin : g_last
      assign en[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid
      assign en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_d = (en & v_in) | (~en & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o = en[ST1];

  // --------------------------------------------------------------------------
  // Stage 1: magnitude clamped to one, expo select, threshold and clamp.
  // Any magnitude above one ends at one whether or not expo applies.
  always_comb begin
    e_raw = '0;
    case (axis_sel_i)
      AXIS_ROLL:  e_raw = rate_mode_q ? first_expo_q[AXIS_ROLL] : second_expo_q[AXIS_ROLL];
      AXIS_PITCH: e_raw = rate_mode_q ? first_expo_q[AXIS_PITCH]
                                      : second_expo_q[AXIS_PITCH];
      AXIS_YAW:   e_raw = rate_mode_q ? first_expo_q[AXIS_YAW] : second_expo_q[AXIS_YAW];
      default:    e_raw = '0;
    endcase
  end

  assign xs    = XW'(stick_value_i);
  assign ax    = xs[XW-1] ? XW'(-xs) : XW'(xs);
  assign ax_a  = AW'(ax);
  assign m1    = (ax_a > ONE_A) ? ONE_A : ax_a;
  assign e_ext = EW'($signed(e_raw));
  assign e100  = e_ext * HUNDRED;
  assign eu    = (e_ext > ONE_E) ? ONE_E : e_ext;

  always_ff @(posedge clk_i) begin
    if (en[ST1]) begin
      s1_axis_q <= axis_sel_i;
      s1_raw_q  <= stick_value_i;
      s1_neg_q  <= stick_value_i[VAL_W-1];
      s1_thr_q  <= (axis_sel_i == AXIS_THROTTLE);
      s1_exp_q  <= (e100 > ONE_E);
      s1_m_q    <= MW'(m1);
      s1_e_q    <= MW'(eu);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: m^2, rounded
  assign p2 = PW'(s1_m_q) * PW'(s1_m_q) + HALF_P;

  always_ff @(posedge clk_i) begin
    if (en[ST2]) begin
      s2_axis_q <= s1_axis_q;
      s2_raw_q  <= s1_raw_q;
      s2_neg_q  <= s1_neg_q;
      s2_thr_q  <= s1_thr_q;
      s2_exp_q  <= s1_exp_q;
      s2_m_q    <= s1_m_q;
      s2_e_q    <= s1_e_q;
      s2_m2_q   <= p2[FRAC_BITS +: MW];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: m^3, rounded; keep m - m^3 (never negative for m at most one)
  assign p3 = PW'(s2_m2_q) * PW'(s2_m_q) + HALF_P;
  assign m3 = p3[FRAC_BITS +: MW];

  always_ff @(posedge clk_i) begin
    if (en[ST3]) begin
      s3_axis_q <= s2_axis_q;
      s3_raw_q  <= s2_raw_q;
      s3_neg_q  <= s2_neg_q;
      s3_thr_q  <= s2_thr_q;
      s3_exp_q  <= s2_exp_q;
      s3_m_q    <= s2_m_q;
      s3_e_q    <= s2_e_q;
      s3_d_q    <= s2_m_q - m3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: m^3*e + m*(1-e) written as m*1 - (m - m^3)*e, rounded
  assign y4 = (PW'(s3_m_q) << FRAC_BITS) - PW'(s3_d_q) * PW'(s3_e_q) + HALF_P;

  always_ff @(posedge clk_i) begin
    if (en[ST4]) begin
      s4_axis_q <= s3_axis_q;
      s4_raw_q  <= s3_raw_q;
      s4_neg_q  <= s3_neg_q;
      s4_thr_q  <= s3_thr_q;
      s4_mag_q  <= s3_exp_q ? y4[FRAC_BITS +: MW] : s3_m_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: deadband test and divider setup.
  // Numerator (|x|-db)*one + den/2; quotient never exceeds one.
  assign db_d  = DW'(dead_zone_q);
  assign mag_d = DW'(s4_mag_q);
  assign den5  = ONE_M - MW'(db_d);
  assign diff5 = s4_mag_q - MW'(db_d);
  assign num5  = (PW'(diff5) << FRAC_BITS) + PW'(den5 >> 1);

  always_comb begin
    s5_d.axis   = s4_axis_q;
    s5_d.raw    = s4_raw_q;
    s5_d.neg    = s4_neg_q;
    s5_d.thr    = s4_thr_q;
    s5_d.bypass = (dead_zone_q == '0);
    s5_d.zero   = (mag_d <= db_d);
    s5_d.mag    = s4_mag_q;
    s5_d.den    = den5;
    s5_d.rem    = MW'(num5[QW +: FRAC_BITS]);
    s5_d.nq     = num5[QW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[ST5]) begin
      s5_q <= s5_d;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage, shifted into nq
  for (genvar k = 0; k < QW; k++) begin : g_div
    div_t          src;
    logic [MW:0]   t;
    logic          ge;

    assign src = (k == 0) ? s5_q : dv_q[(k == 0) ? 0 : k - 1];
    assign t   = {src.rem, src.nq[QW-1]};
    assign ge  = (t >= {1'b0, src.den});

    always_comb begin
      dv_d[k]     = src;
      dv_d[k].rem = ge ? MW'(t - {1'b0, src.den}) : MW'(t);
      dv_d[k].nq  = {src.nq[QW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_DIV0 + k]) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: pick result, restore sign, saturate to the field
  assign fin  = dv_q[QW-1];
  assign umag = fin.bypass ? fin.mag : (fin.zero ? '0 : fin.nq);
  assign sv   = fin.neg ? -OW'(umag) : OW'(umag);
  assign sat  = (sv > VMAX) ? VMAX : ((sv < VMIN) ? VMIN : sv);

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_axis_q <= fin.axis;
      out_val_q  <= fin.thr ? fin.raw : VAL_W'(sat);
    end
  end

  assign out_valid_o    = v_q[ST_OUT];
  assign axis_out_o     = out_axis_q;
  assign shaped_value_o = out_val_q;

endmodule

// ===== design/sedshp_checker.sv =====
// ============================================================================
// sedshp_checker
// Port-level checks of the stick shaper, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "stick_expo_deadband_shaper_defines.svh"
module sedshp_checker import sedshp_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [AXIS_W-1:0]       axis_out_o,
  input logic signed [VAL_W-1:0] shaped_value_o
);

  // Shaped axes stay within one, or the field limits when one is wider
  localparam int LIM_HI = (FRAC_BITS > VAL_W - 2) ? (1 << (VAL_W - 1)) - 1 : (1 << FRAC_BITS);
  localparam int LIM_LO = (FRAC_BITS > VAL_W - 2) ? -(1 << (VAL_W - 1)) : -(1 << FRAC_BITS);

  logic                      stall;
  logic [AXIS_W+VAL_W-1:0]   out_word;
  logic                      shaped_word;
  logic                      val_in_range;

  assign stall        = out_valid_o && !out_ready_i;
  assign out_word     = {axis_out_o, shaped_value_o};
  assign shaped_word  = out_valid_o && (axis_out_o != AXIS_THROTTLE);
  assign val_in_range = (int'(shaped_value_o) <= LIM_HI) && (int'(shaped_value_o) >= LIM_LO);

  // A stalled output word holds
  `SEDSHP_ASSERT_RST(a_hold, stall |=> out_valid_o && $stable(out_word), "stalled word changed")

  // No word comes out of reset
  `SEDSHP_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "output valid during reset")

  // An empty output register never blocks the input
  `SEDSHP_ASSERT_RST(a_ready_free, !out_valid_o |-> in_ready_o, "input blocked with empty output")

  // Roll, pitch and yaw results stay in range
  `SEDSHP_ASSERT_RST(a_range, shaped_word |-> val_in_range, "shaped value out of range")

endmodule

bind stick_expo_deadband_shaper sedshp_checker #(.FRAC_BITS(FRAC_BITS)) u_sedshp_checker (.*);

// ===== verif/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the stick expo / deadband shaper. A driver and a
// monitor run as clocked processes; a bit-accurate predictor computes each
// shaped word as samples are accepted. Directed phases cover the extremes and
// corner cases. Randomized phases with random register settings follow. Both
// channels idle at random, and one long output hold-off backs up the pipeline.
// ============================================================================
`timescale 1ns / 1ps
module testbench;
  import sedshp_pkg::*;

  localparam int  FRAC_BITS   = 14;
  localparam longint ONE      = longint'(1) << FRAC_BITS;
  localparam longint HALF     = ONE >> 1;
  localparam int  PIPE_LAT    = FRAC_BITS + 7;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  RAND_PHASES = 8;
  localparam int  PHASE_WORDS = 117;

  typedef struct {
    logic [AXIS_W-1:0]       axis;
    logic signed [VAL_W-1:0] value;
  } stick_word_t;

  // DUT ports
  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic [AXIS_W-1:0]       axis_sel_i     = '0;
  logic signed [VAL_W-1:0] stick_value_i  = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic [AXIS_W-1:0]       axis_out_o;
  logic signed [VAL_W-1:0] shaped_value_o;
  logic                    cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i     = '0;

  // Shadow copy of the configuration registers
  logic                    rate_mode_sh = 1'b0;
  logic signed [VAL_W-1:0] expo_first_sh  [NUM_SHAPED] = '{default: '0};
  logic signed [VAL_W-1:0] expo_second_sh [NUM_SHAPED] = '{default: '0};
  logic [DZ_W-1:0]         dead_zone_sh = '0;

  stick_word_t stick_q[$];    // samples waiting to be sent
  stick_word_t shaped_q[$];   // shaped words still to come out
  int          errors   = 0;
  int          words_in = 0;
  bit          in_fire  = 1'b0;
  int          cycle_cnt = 0;

  stick_expo_deadband_shaper #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .axis_sel_i     (axis_sel_i),
    .stick_value_i  (stick_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .axis_out_o     (axis_out_o),
    .shaped_value_o (shaped_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Expected word for one stick sample under the current shadow registers
  function automatic stick_word_t shape_stick(logic [AXIS_W-1:0] axis,
                                              logic signed [VAL_W-1:0] raw);
    stick_word_t res;
    longint x, e, m, m2, m3, y, den;
    bit neg;
    x = longint'(raw);
    if (axis != AXIS_THROTTLE) begin
      e = rate_mode_sh ? longint'(expo_first_sh[axis]) : longint'(expo_second_sh[axis]);
      if (e > ONE) e = ONE;
      if (e < -ONE) e = -ONE;
      // expo only above one percent
      if (e * 100 > ONE) begin
        neg = x < 0;
        m   = neg ? -x : x;
        m2  = (m * m + HALF) >>> FRAC_BITS;
        m3  = (m2 * m + HALF) >>> FRAC_BITS;
        y   = m3 * e + m * (ONE - e);
        m   = (y + HALF) >>> FRAC_BITS;
        x   = neg ? -m : m;
      end
      if (x > ONE) x = ONE;
      if (x < -ONE) x = -ONE;
      // deadband with rescale of what is left
      if (dead_zone_sh != 0) begin
        neg = x < 0;
        m   = neg ? -x : x;
        den = ONE - longint'(dead_zone_sh);
        if (m <= longint'(dead_zone_sh) || den <= 0) begin
          m = 0;
        end else begin
          m = ((m - longint'(dead_zone_sh)) * ONE + den / 2) / den;
        end
        x = neg ? -m : m;
      end
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
    end
    res.axis  = axis;
    res.value = x[VAL_W-1:0];
    return res;
  endfunction

  // Raise a register write for one cycle; caller drops the enable afterwards
  task automatic set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_RATE_MODE:         rate_mode_sh                  = data[0];
      REG_FIRST_ROLL_EXPO:   expo_first_sh[AXIS_ROLL]      = data;
      REG_FIRST_PITCH_EXPO:  expo_first_sh[AXIS_PITCH]     = data;
      REG_FIRST_YAW_EXPO:    expo_first_sh[AXIS_YAW]       = data;
      REG_SECOND_ROLL_EXPO:  expo_second_sh[AXIS_ROLL]     = data;
      REG_SECOND_PITCH_EXPO: expo_second_sh[AXIS_PITCH]    = data;
      REG_SECOND_YAW_EXPO:   expo_second_sh[AXIS_YAW]      = data;
      REG_DEAD_ZONE:         dead_zone_sh                  = data[DZ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_stick(logic [AXIS_W-1:0] axis, int value);
    stick_word_t w;
    w.axis  = axis;
    w.value = value[VAL_W-1:0];
    stick_q.push_back(w);
  endtask

  // Block until every sample is sent and shaped, then let the pipe settle
  task automatic wait_idle();
    while (stick_q.size() != 0 || shaped_q.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (PIPE_LAT + 8) @(negedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_expo();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      2: v = 16'sd16384;
      3: v = -16'sd16384;
      4: v = 16'sd164;       // first value above one percent
      5: v = 16'sd163;
      6: v = '0;
      7: v = 16'($urandom());
      default: v = 16'($urandom_range(0, 16384));
    endcase
    return v;
  endfunction

  function automatic int pick_stick();
    int v;
    case ($urandom_range(0, 6))
      0: v = $signed(16'($urandom()));
      1: begin
        case ($urandom_range(0, 8))
          0: v = 32767;
          1: v = -32768;
          2: v = 16384;
          3: v = -16384;
          4: v = 16385;
          5: v = -16385;
          6: v = 1;
          7: v = -1;
          default: v = 0;
        endcase
      end
      2: begin
        // around the dead zone edge
        v = int'(dead_zone_sh) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = int'($urandom_range(0, 32768)) - 16384;
    endcase
    return v;
  endfunction

  task automatic run_random_phase(int n);
    logic [CFG_DATA_W-1:0] dz;
    case ($urandom_range(0, 5))
      0, 1: dz = '0;
      2: dz = 16'(DZ_W'(16383));
      3: dz = 16'($urandom_range(1, 2000));
      default: dz = 16'($urandom());
    endcase
    // upper bits of the narrow registers carry random noise
    set_reg(REG_RATE_MODE, 16'($urandom()));
    set_reg(REG_FIRST_ROLL_EXPO, pick_expo());
    set_reg(REG_FIRST_PITCH_EXPO, pick_expo());
    set_reg(REG_FIRST_YAW_EXPO, pick_expo());
    set_reg(REG_SECOND_ROLL_EXPO, pick_expo());
    set_reg(REG_SECOND_PITCH_EXPO, pick_expo());
    set_reg(REG_SECOND_YAW_EXPO, pick_expo());
    set_reg(REG_DEAD_ZONE, dz);
    end_writes();
    repeat (n) push_stick(2'($urandom_range(0, 3)), pick_stick());
    wait_idle();
  endtask

  // Input driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) stick_q.pop_front();
      if (!(in_valid_i && !in_fire)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (stick_q.size() != 0) begin
          in_valid_i    <= 1'b1;
          axis_sel_i    <= stick_q[0].axis;
          stick_value_i <= stick_q[0].value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output receiver: changing stall patterns plus one long hold-off
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  mode      = 0;
  int  mode_left = 0;
  int  pat_cnt   = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      pat_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && words_in > 300 && stick_q.size() > 40) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ((pat_cnt % 5) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: predict on input words, check output words in order
  always @(posedge clk_i) begin
    stick_word_t want;
    if (rst_ni) begin
      in_fire = in_valid_i && in_ready_o;
      if (in_fire) begin
        shaped_q.push_back(shape_stick(axis_sel_i, stick_value_i));
        words_in++;
      end
      if (out_valid_o && out_ready_i) begin
        if (shaped_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual axis %0d value %0d",
                   $time, axis_out_o, shaped_value_o);
        end else begin
          want = shaped_q.pop_front();
          if (axis_out_o !== want.axis) begin
            errors++;
            $display("%0t: axis_out mismatch: expected %0d, actual %0d",
                     $time, want.axis, axis_out_o);
          end
          if (shaped_value_o !== want.value) begin
            errors++;
            $display("%0t: shaped_value mismatch: expected %0d, actual %0d",
                     $time, want.value, shaped_value_o);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus sequence
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // Reset values: no expo, no deadband, clamp only
    push_stick(AXIS_THROTTLE, 32767);
    push_stick(AXIS_THROTTLE, -32768);
    push_stick(AXIS_ROLL, 32767);
    push_stick(AXIS_PITCH, -32768);
    push_stick(AXIS_YAW, 1);
    wait_idle();

    // First set: expo clamped from above, just over and just under one percent
    set_reg(REG_RATE_MODE, 16'h0001);
    set_reg(REG_FIRST_ROLL_EXPO, 16'h7FFF);
    set_reg(REG_FIRST_PITCH_EXPO, 16'd164);
    set_reg(REG_FIRST_YAW_EXPO, 16'd163);
    set_reg(REG_SECOND_ROLL_EXPO, 16'h8000);
    set_reg(REG_SECOND_PITCH_EXPO, 16'd16384);
    set_reg(REG_SECOND_YAW_EXPO, -16'sd16384);
    set_reg(REG_DEAD_ZONE, 16'hC000);
    end_writes();
    push_stick(AXIS_ROLL, 16384);
    push_stick(AXIS_ROLL, -12000);
    push_stick(AXIS_PITCH, 16384);
    push_stick(AXIS_PITCH, -8192);
    push_stick(AXIS_YAW, 8192);
    push_stick(AXIS_THROTTLE, 1234);
    wait_idle();

    // Second set, widest dead zone; negative expo skips the curve
    set_reg(REG_RATE_MODE, 16'hFFFE);
    set_reg(REG_DEAD_ZONE, 16'h3FFF);
    end_writes();
    push_stick(AXIS_ROLL, 16384);
    push_stick(AXIS_ROLL, -16383);
    push_stick(AXIS_PITCH, 16384);
    push_stick(AXIS_YAW, 20000);
    wait_idle();

    // Narrow dead zone: magnitude equal to it and one above
    set_reg(REG_SECOND_PITCH_EXPO, 16'd8192);
    set_reg(REG_DEAD_ZONE, 16'd100);
    end_writes();
    push_stick(AXIS_PITCH, 100);
    push_stick(AXIS_PITCH, -101);
    push_stick(AXIS_ROLL, 100);
    push_stick(AXIS_ROLL, 101);
    push_stick(AXIS_YAW, -16384);
    push_stick(AXIS_THROTTLE, -5);
    wait_idle();

    repeat (RAND_PHASES) run_random_phase(PHASE_WORDS);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
